[hw/rtl/huffman_tree_walk_decoder_assert.svh]
// Assertion macros for the Huffman tree walk decoder.
// Define ASSERT_OFF to compile the checks out.
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HTWD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HTWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HTWD_ASSERT(lbl, clk, rst, prop, msg)
`define HTWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[hw/rtl/htwd_pkg.sv]
// Shared types and constants of the Huffman tree walk decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htwd_pkg;

   localparam int IDX_W   = 9;
   localparam int SYM_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 4;
   localparam int TOP_BIT = 7;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_DECODE  = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [IDX_W-1:0]  node_index;
      logic [IDX_W-1:0]  left_child;
      logic [IDX_W-1:0]  right_child;
      logic              is_leaf;
      logic [SYM_W-1:0]  leaf_symbol;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  valid_bits;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             leaf;
      logic [SYM_W-1:0] sym;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic load;
      logic restart;
      logic start;
      logic fetch;
      logic step;
      logic look;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic step_read;
      logic nxt_leaf;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[hw/rtl/htwd_chan_if.sv]
// Valid/ready channel carrying one item of a given payload type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface htwd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/huffman_tree_walk_decoder.sv]
// Huffman tree walk decoder: load items write node table entries, decode items
// walk the tree MSB first and emit one item per leaf reached, restart items rewind.
// A decode item holds off further items until its walk ends, and it stalls while
// the output is full: each step waits on one dependent node table read. Reset puts
// the walk at the root; the table is not cleared.
// Depends on htwd_pkg, htwd_chan_if, htwd_ctrl and htwd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = 512
) (
   input  logic        clock,
   input  logic        reset,
   htwd_chan_if.sink   req_if,
   htwd_chan_if.source rsp_if
);
   import htwd_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   htwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.data.mode),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   htwd_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_if.data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign rsp_if.data  = rsp_data;
endmodule

`default_nettype wire

[hw/rtl/htwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htwd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

[hw/rtl/htwd_datapath.sv]
// Datapath: node table, walk registers, pending symbol and output register.
// Depends on htwd_pkg, htwd_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_walk_decoder_assert.svh"

module htwd_datapath #(
   parameter int NODE_COUNT = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  htwd_pkg::req_type req_data,
   output htwd_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  htwd_pkg::cmd_type cmd,
   output htwd_pkg::sts_type sts
);
   import htwd_pkg::*;

   localparam int ADDR_W = $clog2(NODE_COUNT);

   node_type          root_ff;
   node_type          cur_ff;
   node_type          eff;
   node_type          ram_q;
   node_type          load_node;
   logic [IDX_W-1:0]  current_ff;
   logic [IDX_W-1:0]  child_ff;
   logic [IDX_W-1:0]  child;
   logic [BYTE_W-1:0] bits_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_start;
   logic              pend_valid_ff;
   logic [SYM_W-1:0]  pend_sym_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              idx_ok;
   logic              child_ok;
   logic              step_read;
   logic              push;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   assign load_node = '{left:  req_data.left_child,
                        right: req_data.right_child,
                        leaf:  req_data.is_leaf,
                        sym:   req_data.leaf_symbol};
   assign idx_ok    = 32'(req_data.node_index) < NODE_COUNT;
   assign cnt_start = (req_data.valid_bits > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W)
                                                             : req_data.valid_bits;

   // a leaf as current node means the walk restarts from the root
   assign eff       = cur_ff.leaf ? root_ff : cur_ff;
   assign child     = bits_ff[TOP_BIT] ? eff.right : eff.left;
   assign child_ok  = 32'(child) < NODE_COUNT;
   assign step_read = (cnt_ff != '0) && !eff.leaf && child_ok;

   assign wr_en   = cmd.load && idx_ok;
   assign rd_en   = cmd.start || (cmd.step && step_read);
   assign rd_addr = cmd.start ? ADDR_W'(current_ff) : ADDR_W'(child);

   htwd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_data.node_index)),
      .wr_data (load_node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign push = (cmd.look && ram_q.leaf && pend_valid_ff) || (cmd.flush && pend_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         current_ff    <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (wr_en && (req_data.node_index == '0)) begin
            root_ff <= load_node;
         end
         if (cmd.restart) begin
            current_ff <= '0;
         end
         if (cmd.start) begin
            cnt_ff <= cnt_start;
         end
         if (cmd.step) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (!step_read) begin
               current_ff <= '0;
            end
         end
         if (cmd.look) begin
            if (ram_q.leaf) begin
               current_ff    <= '0;
               pend_valid_ff <= 1'b1;
            end else begin
               current_ff <= child_ff;
            end
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         bits_ff <= req_data.data_byte;
      end
      if (cmd.fetch) begin
         cur_ff <= ram_q;
      end
      if (cmd.step) begin
         bits_ff  <= bits_ff << 1;
         child_ff <= child;
         if (!step_read) begin
            cur_ff <= root_ff;
         end
      end
      if (cmd.look) begin
         cur_ff <= ram_q.leaf ? root_ff : ram_q;
         if (ram_q.leaf) begin
            pend_sym_ff <= ram_q.sym;
         end
      end
      if (push) begin
         rsp_ff <= '{symbol: pend_sym_ff, last: cmd.flush};
      end
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts = '{cnt_zero:   cnt_ff == '0,
                  step_read:  step_read,
                  nxt_leaf:   ram_q.leaf,
                  pend_valid: pend_valid_ff,
                  out_free:   !rsp_valid_ff || rsp_ready};

   `HTWD_ASSERT(a_current_in_range, clock, reset, 32'(current_ff) < NODE_COUNT, "walk left table")
   `HTWD_ASSERT(a_rsp_rise_from_push, clock, reset, $rose(rsp_valid_ff) |-> $past(push), "stray rsp")
endmodule

`default_nettype wire

[hw/rtl/htwd_ctrl.sv]
// Controller: sequences load, restart and decode items over the datapath.
// Depends on htwd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_walk_decoder_assert.svh"

module htwd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_mode,
   output logic              req_ready,
   input  htwd_pkg::sts_type sts,
   output htwd_pkg::cmd_type cmd
);
   import htwd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_LOOK,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      accept;

   assign accept = req_valid && ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  MODE_DECODE: begin
                     cmd.start = 1'b1;
                     state_in  = ST_FETCH;
                  end
                  MODE_RESTART: begin
                     cmd.restart = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (sts.cnt_zero) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.step = 1'b1;
               if (sts.step_read) begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            // a new symbol displaces the pending one, which needs room in the output
            if (!(sts.nxt_leaf && sts.pend_valid && !sts.out_free)) begin
               cmd.look = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

   `HTWD_ASSERT(a_idle_none_pending, clock, reset, (state_ff == ST_IDLE) |-> !sts.pend_valid, "symbol left pending")
   `HTWD_ASSERT(a_push_has_room, clock, reset, ((cmd.look && sts.nxt_leaf && sts.pend_valid) || cmd.flush) |-> sts.out_free, "output overrun")
   `HTWD_ASSERT_NEXT(a_start_fetches, clock, reset, cmd.start, state_ff == ST_FETCH, "decode start lost")
endmodule

`default_nettype wire
